// ----- design/srbs_pkg.sv -----
// ----------------------------------------------------------------------------
// srbs_pkg: shared types and constants for the sync retry backoff scheduler
// Operation codes, time source codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package srbs_pkg;

   // request operation codes
   localparam logic [1:0] OP_TICK          = 2'd0;
   localparam logic [1:0] OP_EXT_REPORT    = 2'd1;
   localparam logic [1:0] OP_PROV_REPORT   = 2'd2;

   // time source codes
   localparam logic [1:0] SRC_NONE         = 2'd0;
   localparam logic [1:0] SRC_LOCAL        = 2'd1;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W     = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFRESH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLOOR   = 3'd4;

   localparam int unsigned CSR_DATA_W      = 33;

   // register reset values
   localparam logic [23:0] BASE_RETRY_RESET   = 24'd60000;
   localparam logic [31:0] MAX_RETRY_RESET    = 32'd900000;
   localparam logic [31:0] REFRESH_RESET      = 32'd10800000;
   localparam logic [32:0] EPOCH_FLOOR_RESET  = 33'd1700000000;

   localparam logic [7:0]  RETRY_SAT          = 8'd255;

   // one accepted request
   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] now_ms;
      logic        link_up;
      logic [32:0] epoch_sec;
      logic [1:0]  sync_source;
   } req_item_type;

   // one result
   typedef struct packed {
      logic       request_sync;
      logic       is_synced;
      logic [1:0] time_source;
      logic [7:0] retries_done;
   } rsp_item_type;

endpackage

// ----- design/sync_retry_backoff_scheduler.sv -----
// ----------------------------------------------------------------------------
// sync_retry_backoff_scheduler: time sync request scheduler with backoff
// Tick requests carry the millisecond count, link state and clock epoch;
// report requests record a successful sync. Each request yields one result:
// whether a sync attempt is issued now, whether the clock counts as synced,
// the current time source and the retry count. Unsynced clocks with a link
// are retried with exponential backoff, synced clocks are refreshed.
//
// Channels: req_* in, rsp_* out, both valid/stall; csr_* is a plain write
// port (index 0 enable, 1 base, 2 max, 3 refresh, 4 epoch floor).
// A request passes the input register, then the result register, before it
// shows on rsp_*. Throughput is one request per cycle while rsp_stall is
// low; the state update for a request is written together with its result,
// so the next request in the input register sees it at once.
// Reset clears both stages, the scheduling state and loads the register
// defaults. While rsp_stall holds a waiting result, one more request is
// taken into the input register, then req_stall rises until the result
// register drains.
// ----------------------------------------------------------------------------
module sync_retry_backoff_scheduler
   import srbs_pkg::*;
#(
   parameter int BACKOFF_STEPS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_operation,
   input  logic [31:0]            req_now_ms,
   input  logic                   req_link_up,
   input  logic [32:0]            req_epoch_sec,
   input  logic [1:0]             req_sync_source,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_request_sync,
   output logic                   rsp_is_synced,
   output logic [1:0]             rsp_time_source,
   output logic [7:0]             rsp_retries_done,
   // configuration port
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // configuration registers
   logic        enable_ff;
   logic [23:0] base_retry_ff;
   logic [31:0] max_retry_ff;
   logic [31:0] refresh_ff;
   logic [32:0] epoch_floor_ff;

   // scheduling state
   logic [7:0]  retry_count_ff,     retry_count_in;
   logic        prev_link_ff,       prev_link_in;
   logic [31:0] last_attempt_ff,    last_attempt_in;
   logic [31:0] last_success_ff,    last_success_in;
   logic [1:0]  source_ff,          source_in;

   // pipeline registers
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type out_item_in;

   logic        advance;
   logic        take_req;
   logic [31:0] backoff_ms;
   logic [31:0] since_success;
   logic [31:0] since_attempt;
   logic [7:0]  retry_cleared;

   // move the input stage whenever the result register is free or drains
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign take_req  = req_valid && !req_stall;

   // hold the request in the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take_req) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (take_req) begin
         in_item_ff.operation   <= req_operation;
         in_item_ff.now_ms      <= req_now_ms;
         in_item_ff.link_up     <= req_link_up;
         in_item_ff.epoch_sec   <= req_epoch_sec;
         in_item_ff.sync_source <= req_sync_source;
      end
   end

   // elapsed times wrap modulo 2^32
   assign since_success = in_item_ff.now_ms - last_success_ff;
   assign since_attempt = in_item_ff.now_ms - last_attempt_ff;

   // a rising link clears the count before the backoff is chosen
   assign retry_cleared = (in_item_ff.link_up && !prev_link_ff) ? 8'd0 : retry_count_ff;

   // pick the backoff interval: shifted base below the step limit, else the cap
   always_comb begin
      if (retry_cleared < 8'(BACKOFF_STEPS)) begin
         backoff_ms = {8'd0, base_retry_ff} << retry_cleared[2:0];
      end else begin
         backoff_ms = max_retry_ff;
      end
   end

   // compute the next state and the result for the held request
   always_comb begin
      retry_count_in  = retry_count_ff;
      prev_link_in    = prev_link_ff;
      last_attempt_in = last_attempt_ff;
      last_success_in = last_success_ff;
      source_in       = source_ff;
      out_item_in.request_sync = 1'b0;
      out_item_in.is_synced    = 1'b0;

      if (in_item_ff.operation == OP_TICK && enable_ff) begin
         retry_count_in = retry_cleared;
         prev_link_in   = in_item_ff.link_up;
         if (in_item_ff.epoch_sec > epoch_floor_ff) begin
            out_item_in.is_synced = 1'b1;
            if (source_ff == SRC_NONE) begin
               source_in = SRC_LOCAL;
            end
            if (since_success >= refresh_ff && in_item_ff.link_up) begin
               out_item_in.request_sync = 1'b1;
               last_attempt_in          = in_item_ff.now_ms;
            end
         end else begin
            source_in = SRC_NONE;
            if (in_item_ff.link_up && since_attempt >= backoff_ms) begin
               if (retry_cleared != RETRY_SAT) begin
                  retry_count_in = retry_cleared + 8'd1;
               end
               last_attempt_in          = in_item_ff.now_ms;
               out_item_in.request_sync = 1'b1;
            end
         end
      end else if ((in_item_ff.operation == OP_EXT_REPORT && enable_ff) ||
                   in_item_ff.operation == OP_PROV_REPORT) begin
         source_in       = in_item_ff.sync_source;
         last_success_in = in_item_ff.now_ms;
         retry_count_in  = 8'd0;
      end

      out_item_in.time_source  = source_in;
      out_item_in.retries_done = retry_count_in;
   end

   // update on advance; user writes configuration only while idle, unenforced
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b1;
         base_retry_ff   <= BASE_RETRY_RESET;
         max_retry_ff    <= MAX_RETRY_RESET;
         refresh_ff      <= REFRESH_RESET;
         epoch_floor_ff  <= EPOCH_FLOOR_RESET;
         retry_count_ff  <= 8'd0;
         prev_link_ff    <= 1'b0;
         last_attempt_ff <= 32'd0;
         last_success_ff <= 32'd0;
         source_ff       <= SRC_NONE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENABLE: begin
               enable_ff      <= csr_write_data[0];
               retry_count_ff <= 8'd0;
            end
            CSR_BASE:    base_retry_ff  <= csr_write_data[23:0];
            CSR_MAX:     max_retry_ff   <= csr_write_data[31:0];
            CSR_REFRESH: refresh_ff     <= csr_write_data[31:0];
            CSR_FLOOR:   epoch_floor_ff <= csr_write_data;
            default: begin
            end
         endcase
      end else if (advance) begin
         retry_count_ff  <= retry_count_in;
         prev_link_ff    <= prev_link_in;
         last_attempt_ff <= last_attempt_in;
         last_success_ff <= last_success_in;
         source_ff       <= source_in;
      end
   end

   // hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_request_sync = out_item_ff.request_sync;
   assign rsp_is_synced    = out_item_ff.is_synced;
   assign rsp_time_source  = out_item_ff.time_source;
   assign rsp_retries_done = out_item_ff.retries_done;

`ifndef SYNTHESIS
   // a backoff request always leaves a nonzero retry count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_request_sync && !rsp_is_synced) |-> (rsp_retries_done != 8'd0))
      else $error("backoff request with zero retry count");

   // a synced result always names a time source
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_synced) |-> (rsp_time_source != SRC_NONE))
      else $error("synced result without time source");

   // scheduling disabled keeps the retry count at zero
   assert property (@(posedge clock) disable iff (reset)
      !enable_ff |-> (retry_count_ff == 8'd0))
      else $error("retry count moved while disabled");

   // stall toward the sender only while the result side is stalled
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_stall && rsp_valid && in_valid_ff))
      else $error("request stalled without downstream stall");
`endif

endmodule
